>>> hw/rtl/acd_pkg.sv
package acd_pkg;
    localparam int DelayDepthDef = 16;
    localparam int AverageLengthDef = 16;
    localparam int AngW = 16;
    localparam int ErrW = 17;
    localparam int SumW = 24;
    localparam int CfgW = 24;

    localparam logic [2:0] CfgFrameDelay = 3'd0;
    localparam logic [2:0] CfgPitchThr   = 3'd1;
    localparam logic [2:0] CfgRollThr    = 3'd2;
    localparam logic [2:0] CfgMalfLimit  = 3'd3;
    localparam logic [2:0] CfgSpeedRecip = 3'd4;

    localparam logic [3:0] DirNone = 4'd0;
    localparam logic [3:0] DirN    = 4'd1;
    localparam logic [3:0] DirNE   = 4'd2;
    localparam logic [3:0] DirE    = 4'd3;
    localparam logic [3:0] DirSE   = 4'd4;
    localparam logic [3:0] DirS    = 4'd5;
    localparam logic [3:0] DirSW   = 4'd6;
    localparam logic [3:0] DirW    = 4'd7;
    localparam logic [3:0] DirNW   = 4'd8;

    typedef struct packed {
        logic [14:0] pitch_thr;
        logic [14:0] roll_thr;
        logic [15:0] malf_limit;
        logic [23:0] speed_recip;
    } cfg_t;

    typedef struct packed {
        logic        contact;
        logic [15:0] duration;
        logic [3:0]  dir;
    } lane_res_t;

    function automatic logic [3:0] classify(input logic left, input logic cx, input logic cy,
                                            input logic sx_pos, input logic sx_neg,
                                            input logic sy_neg);
        logic [3:0] d;
        d = DirNone;
        if (cx && cy)
            d = sx_pos ? (sy_neg ? DirNW : DirNE) : (sy_neg ? DirSW : DirSE);
        else if (cx)
            d = sx_neg ? DirS : DirN;
        else if (cy)
            d = sy_neg ? DirW : DirE;
        if (left) begin
            case (d)
                DirNE:   d = DirNW;
                DirNW:   d = DirNE;
                DirE:    d = DirW;
                DirW:    d = DirE;
                DirSE:   d = DirSW;
                DirSW:   d = DirSE;
                default: d = d;
            endcase
        end
        return d;
    endfunction
endpackage

>>> hw/rtl/acd_lane.sv
module acd_lane #(
    parameter int AVERAGE_LENGTH = acd_pkg::AverageLengthDef,
    parameter bit IS_LEFT = 1'b0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           clear,
    input  logic                           active,
    input  logic signed [acd_pkg::ErrW-1:0] err_pitch,
    input  logic signed [acd_pkg::ErrW-1:0] err_roll,
    input  logic [15:0]                    speed,
    input  acd_pkg::cfg_t                  cfg,
    output acd_pkg::lane_res_t             res
);
    import acd_pkg::*;

    localparam int IdxW = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
    localparam int CntW = $clog2(AVERAGE_LENGTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_FACT, S_MUL, S_ADD, S_CMP} state_t;
    state_t state_reg;

    logic signed [15:0] ring_p_reg [AVERAGE_LENGTH];
    logic signed [15:0] ring_r_reg [AVERAGE_LENGTH];
    logic [IdxW-1:0] head_reg;
    logic [CntW-1:0] count_reg;
    logic signed [SumW-1:0] sum_p_reg, sum_r_reg;
    logic [15:0] dur_reg;
    logic [39:0] q_reg;
    logic [15:0] fact_reg;
    logic [32:0] prod_p_reg, prod_r_reg;
    logic neg_p_reg, neg_r_reg;
    logic [16:0] mag_p_reg, mag_r_reg;
    logic [16:0] mag_p, mag_r;
    logic signed [15:0] sc_p, sc_r;
    logic [38:0] lim_p, lim_r;
    logic [SumW-1:0] abs_p, abs_r;
    logic cx, cy, raw;
    logic [15:0] dur_next;

    assign mag_p = err_pitch[ErrW-1] ? 17'(-err_pitch) : 17'(err_pitch);
    assign mag_r = err_roll[ErrW-1] ? 17'(-err_roll) : 17'(err_roll);

    function automatic logic signed [15:0] sat_round(input logic [32:0] pr, input logic neg);
        logic [17:0] r;
        r = 18'((pr + 33'd16384) >> 15);
        if (neg) return (r > 18'd32768) ? -16'sd32768 : 16'(-r);
        return (r > 18'd32767) ? 16'sd32767 : 16'(r);
    endfunction

    assign sc_p = sat_round(prod_p_reg, neg_p_reg);
    assign sc_r = sat_round(prod_r_reg, neg_r_reg);
    assign abs_p = sum_p_reg[SumW-1] ? SumW'(-sum_p_reg) : SumW'(sum_p_reg);
    assign abs_r = sum_r_reg[SumW-1] ? SumW'(-sum_r_reg) : SumW'(sum_r_reg);
    assign lim_p = 39'(cfg.pitch_thr) * 39'(count_reg);
    assign lim_r = 39'(cfg.roll_thr) * 39'(count_reg);
    assign cx = 39'(abs_p) > lim_p;
    assign cy = 39'(abs_r) > lim_r;
    assign raw = cx || cy;
    assign dur_next = !raw ? 16'd0 : ((dur_reg == 16'hFFFF) ? dur_reg : dur_reg + 16'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            sum_p_reg <= '0;
            sum_r_reg <= '0;
            dur_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        if (clear) begin
                            head_reg  <= '0;
                            count_reg <= '0;
                            sum_p_reg <= '0;
                            sum_r_reg <= '0;
                        end
                        if (active) begin
                            q_reg     <= 40'(speed) * 40'(cfg.speed_recip);
                            neg_p_reg <= err_pitch[ErrW-1];
                            neg_r_reg <= err_roll[ErrW-1];
                            // error inputs are only valid in the accept cycle
                            mag_p_reg <= mag_p;
                            mag_r_reg <= mag_r;
                            state_reg <= S_FACT;
                        end
                    end
                end
                S_FACT: begin
                    fact_reg <= (q_reg >= 40'h1000000) ? 16'd0 :
                                16'((40'h1000000 - q_reg) >> 9);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_p_reg <= 33'(mag_p_reg) * 33'(fact_reg);
                    prod_r_reg <= 33'(mag_r_reg) * 33'(fact_reg);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    // oldest entry leaves once the ring is full
                    if (count_reg == CntW'(AVERAGE_LENGTH)) begin
                        sum_p_reg <= sum_p_reg - SumW'(ring_p_reg[head_reg]) + SumW'(sc_p);
                        sum_r_reg <= sum_r_reg - SumW'(ring_r_reg[head_reg]) + SumW'(sc_r);
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        sum_p_reg <= sum_p_reg + SumW'(sc_p);
                        sum_r_reg <= sum_r_reg + SumW'(sc_r);
                    end
                    ring_p_reg[head_reg] <= sc_p;
                    ring_r_reg[head_reg] <= sc_r;
                    head_reg <= (32'(head_reg) == AVERAGE_LENGTH - 1) ? '0 : head_reg + 1'b1;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    dur_reg <= dur_next;
                    res.contact  <= raw && (dur_next < cfg.malf_limit);
                    res.duration <= dur_next;
                    res.dir <= classify(IS_LEFT, cx, cy,
                                        !sum_p_reg[SumW-1] && (sum_p_reg != '0),
                                        sum_p_reg[SumW-1], sum_r_reg[SumW-1]);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/arm_contact_detector.sv
// Arm contact detector. One transaction per control frame: commanded angles enter a
// delay line, and on an active frame each arm lane scales the tracking error by hand
// speed, averages it over a ring, compares with the thresholds and classifies a push
// direction. On an active frame the result is registered after the steps speed
// product, factor, error product, ring update and compare, then merged into the output
// registers; the next transaction is accepted the cycle after the result is taken. An
// inactive frame gives no result. The two arms run as parallel lanes and a merge stage
// tracks the last directions. Configuration writes take effect at once; they are to be
// made only while idle, which the block itself does not enforce.
module arm_contact_detector #(
    parameter int DELAY_DEPTH = acd_pkg::DelayDepthDef,
    parameter int AVERAGE_LENGTH = acd_pkg::AverageLengthDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [acd_pkg::CfgW-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] cmd_left_pitch,
    input  logic signed [15:0] cmd_left_roll,
    input  logic signed [15:0] cmd_right_pitch,
    input  logic signed [15:0] cmd_right_roll,
    input  logic signed [15:0] meas_left_pitch,
    input  logic signed [15:0] meas_left_roll,
    input  logic signed [15:0] meas_right_pitch,
    input  logic signed [15:0] meas_right_roll,
    input  logic [15:0]        left_hand_speed,
    input  logic [15:0]        right_hand_speed,
    input  logic               active,
    input  logic               clear,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               contact_left,
    output logic               contact_right,
    output logic [15:0]        duration_left,
    output logic [15:0]        duration_right,
    output logic [3:0]         dir_left,
    output logic [3:0]         dir_right,
    output logic [3:0]         last_dir_left,
    output logic [3:0]         last_dir_right
);
    import acd_pkg::*;

    localparam int DW = $clog2(DELAY_DEPTH);
    localparam int WaitCycles = 5;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
    state_t state_reg;

    cfg_t cfg_reg;
    logic [3:0] frame_delay_reg;
    logic [63:0] dline_reg [DELAY_DEPTH];
    logic [DELAY_DEPTH-1:0] dvalid_reg;
    logic [DW-1:0] dhead_reg;
    logic [2:0] wait_reg;
    logic [3:0] last_l_reg, last_r_reg;
    logic [DW-1:0] head_new, k, idx;
    logic [63:0] cmd_old, cmd_new;
    logic start;
    logic signed [ErrW-1:0] elp, elr, erp, err;
    lane_res_t res_l, res_r;

    assign in_ready = (state_reg == S_IDLE);
    assign start = in_valid && in_ready;
    assign head_new = (32'(dhead_reg) == DELAY_DEPTH - 1) ? '0 : dhead_reg + 1'b1;
    assign k = (32'(frame_delay_reg) > DELAY_DEPTH - 1) ? DW'(DELAY_DEPTH - 1)
                                                          : DW'(frame_delay_reg);
    assign idx = (head_new >= k) ? head_new - k : DW'(32'(head_new) + DELAY_DEPTH - 32'(k));
    assign cmd_new = {cmd_left_pitch, cmd_left_roll, cmd_right_pitch, cmd_right_roll};
    // unwritten delay entries read as zero; delay zero reads this frame's command
    assign cmd_old = (k == '0) ? cmd_new : (dvalid_reg[idx] ? dline_reg[idx] : 64'd0);
    assign elp = ErrW'(meas_left_pitch)  - ErrW'($signed(cmd_old[63:48]));
    assign elr = ErrW'(meas_left_roll)   - ErrW'($signed(cmd_old[47:32]));
    assign erp = ErrW'(meas_right_pitch) - ErrW'($signed(cmd_old[31:16]));
    assign err = ErrW'(meas_right_roll)  - ErrW'($signed(cmd_old[15:0]));

    acd_lane #(.AVERAGE_LENGTH(AVERAGE_LENGTH), .IS_LEFT(1'b1)) u_lane_l (
        .clk(clk), .rst_n(rst_n), .start(start), .clear(clear), .active(active),
        .err_pitch(elp), .err_roll(elr), .speed(left_hand_speed), .cfg(cfg_reg),
        .res(res_l));
    acd_lane #(.AVERAGE_LENGTH(AVERAGE_LENGTH), .IS_LEFT(1'b0)) u_lane_r (
        .clk(clk), .rst_n(rst_n), .start(start), .clear(clear), .active(active),
        .err_pitch(erp), .err_roll(err), .speed(right_hand_speed), .cfg(cfg_reg),
        .res(res_r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.pitch_thr   <= 15'd100;
            cfg_reg.roll_thr    <= 15'd157;
            cfg_reg.malf_limit  <= 16'd200;
            cfg_reg.speed_recip <= 24'd27962;
            frame_delay_reg <= 4'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgFrameDelay: frame_delay_reg     <= cfg_data[3:0];
                CfgPitchThr:   cfg_reg.pitch_thr   <= cfg_data[14:0];
                CfgRollThr:    cfg_reg.roll_thr    <= cfg_data[14:0];
                CfgMalfLimit:  cfg_reg.malf_limit  <= cfg_data[15:0];
                CfgSpeedRecip: cfg_reg.speed_recip <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            dline_reg[head_new] <= cmd_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            dvalid_reg <= '0;
            dhead_reg  <= '0;
            wait_reg   <= '0;
            last_l_reg <= DirNone;
            last_r_reg <= DirNone;
            out_valid  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        dhead_reg <= head_new;
                        dvalid_reg[head_new] <= 1'b1;
                        if (active) begin
                            wait_reg  <= 3'(WaitCycles);
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (wait_reg == 3'd1) begin
                        // merge both lanes into the result transaction
                        contact_left   <= res_l.contact;
                        contact_right  <= res_r.contact;
                        duration_left  <= res_l.duration;
                        duration_right <= res_r.duration;
                        dir_left       <= res_l.dir;
                        dir_right      <= res_r.dir;
                        last_dir_left  <= (res_l.dir != DirNone) ? res_l.dir : last_l_reg;
                        last_dir_right <= (res_r.dir != DirNone) ? res_r.dir : last_r_reg;
                        if (res_l.dir != DirNone) last_l_reg <= res_l.dir;
                        if (res_r.dir != DirNone) last_r_reg <= res_r.dir;
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    wait_reg <= wait_reg - 3'd1;
                end
                S_OUT: begin
                    if (out_ready) begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_last_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && dir_left != DirNone |-> last_dir_left == dir_left)
        else $error("last left direction not updated");
endmodule
